// ===== hw/rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants for the command frame deframer
// Register indexes, event codes, configuration and result bundles.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CDATA_W = 16;

    localparam logic [IDX_W-1:0] REG_FIRST_HDR  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SECOND_HDR = 3'd1;
    localparam logic [IDX_W-1:0] REG_END_BYTE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_WAKEUP     = 3'd3;
    localparam logic [IDX_W-1:0] REG_DETECTED   = 3'd4;
    localparam logic [IDX_W-1:0] REG_PAYLOAD    = 3'd5;
    localparam logic [IDX_W-1:0] REG_READ_ERR   = 3'd6;
    localparam logic [IDX_W-1:0] REG_MAX_LEN    = 3'd7;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_WAKEUP   = 4'd1,
        EV_DETECTED = 4'd2,
        EV_READERR  = 4'd3,
        EV_START    = 4'd4,
        EV_BYTE     = 4'd5,
        EV_PKTEND   = 4'd6,
        EV_BADCMD   = 4'd7,
        EV_BADLEN   = 4'd8,
        EV_NOEND    = 4'd9
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first_hdr;
        logic [BYTE_W-1:0] second_hdr;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] wakeup_code;
        logic [BYTE_W-1:0] detected_code;
        logic [BYTE_W-1:0] payload_code;
        logic [BYTE_W-1:0] read_err_code;
        logic [LEN_W-1:0]  max_len;
    } cfg_t;

    typedef struct packed {
        event_t            ev;
        logic [BYTE_W-1:0] pbyte;
        logic              plast;
        logic [LEN_W-1:0]  plen;
    } result_t;

endpackage

// ===== hw/rtl/command_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// command_frame_deframer: byte-serial command frame tracker
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   s_       | in        | s_valid / s_ready  | s_rx_byte
//   m_       | out       | m_valid / m_ready  | m_event_res, m_payload_byte,
//            |           |                    | m_payload_last, m_payload_length
//   cfg_     | in        | cfg_wr_en          | cfg_wr_index, cfg_wr_data
//
// One byte per cycle sustained while m_ready is high; each byte gives one result
// through the input register, parser decode and result register.
// Reset sets the parser to wait for the first header byte and loads the
// default codes and length limit.
// With m_ready low, up to two bytes stay in flight before s_ready drops.
// ----------------------------------------------------------------------------
module command_frame_deframer
    import cfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_event_res,
    output logic [BYTE_W-1:0]  m_payload_byte,
    output logic               m_payload_last,
    output logic [LEN_W-1:0]   m_payload_length,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_wr_index,
    input  logic [CDATA_W-1:0] cfg_wr_data
);

    cfg_t              cfg;
    result_t           res;
    result_t           result_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    cfd_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    cfd_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            result_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_event_res      = result_reg.ev;
    assign m_payload_byte   = result_reg.pbyte;
    assign m_payload_last   = result_reg.plast;
    assign m_payload_length = result_reg.plen;

endmodule

// ===== hw/rtl/cfd_regs.sv =====
// ----------------------------------------------------------------------------
// cfd_regs: configuration register file
// Holds header, end and command codes and the payload length limit.
// ----------------------------------------------------------------------------
module cfd_regs
    import cfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_wr_index,
    input  logic [CDATA_W-1:0] cfg_wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_hdr     <= 8'd170;
            cfg_reg.second_hdr    <= 8'd85;
            cfg_reg.end_byte      <= 8'd255;
            cfg_reg.wakeup_code   <= 8'd1;
            cfg_reg.detected_code <= 8'd2;
            cfg_reg.payload_code  <= 8'd3;
            cfg_reg.read_err_code <= 8'd4;
            cfg_reg.max_len       <= 16'd1024;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_FIRST_HDR:  cfg_reg.first_hdr     <= cfg_wr_data[BYTE_W-1:0];
                REG_SECOND_HDR: cfg_reg.second_hdr    <= cfg_wr_data[BYTE_W-1:0];
                REG_END_BYTE:   cfg_reg.end_byte      <= cfg_wr_data[BYTE_W-1:0];
                REG_WAKEUP:     cfg_reg.wakeup_code   <= cfg_wr_data[BYTE_W-1:0];
                REG_DETECTED:   cfg_reg.detected_code <= cfg_wr_data[BYTE_W-1:0];
                REG_PAYLOAD:    cfg_reg.payload_code  <= cfg_wr_data[BYTE_W-1:0];
                REG_READ_ERR:   cfg_reg.read_err_code <= cfg_wr_data[BYTE_W-1:0];
                REG_MAX_LEN:    cfg_reg.max_len       <= cfg_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/cfd_parse.sv =====
// ----------------------------------------------------------------------------
// cfd_parse: frame parser state machine
// Decodes one byte against the current phase and commits on advance.
// ----------------------------------------------------------------------------
module cfd_parse
    import cfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              advance,
    input  logic [BYTE_W-1:0] rx_byte,
    output result_t           res
);

    typedef enum logic [2:0] {
        PH_HEAD0 = 3'd0,
        PH_HEAD1 = 3'd1,
        PH_CMD   = 3'd2,
        PH_LENH  = 3'd3,
        PH_LENL  = 3'd4,
        PH_DATA  = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] exp_len_reg, exp_len_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] len_full;
    logic [LEN_W-1:0] count_inc;
    phase_t           hdr_restart;

    assign len_full    = {exp_len_reg[LEN_W-1:BYTE_W], rx_byte};
    assign count_inc   = count_reg + 16'd1;
    assign hdr_restart = (rx_byte == cfg.first_hdr) ? PH_HEAD1 : PH_HEAD0;

    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        res.ev       = EV_NONE;
        res.pbyte    = '0;
        res.plast    = 1'b0;
        res.plen     = '0;
        case (phase_reg)
            PH_HEAD1: begin
                if (rx_byte == cfg.second_hdr) begin
                    phase_next = PH_CMD;
                end else begin
                    phase_next = hdr_restart;
                end
            end
            PH_CMD: begin
                if (rx_byte == cfg.wakeup_code) begin
                    res.ev     = EV_WAKEUP;
                    phase_next = PH_END;
                end else if (rx_byte == cfg.detected_code) begin
                    res.ev     = EV_DETECTED;
                    phase_next = PH_END;
                end else if (rx_byte == cfg.payload_code) begin
                    exp_len_next = '0;
                    phase_next   = PH_LENH;
                end else if (rx_byte == cfg.read_err_code) begin
                    res.ev     = EV_READERR;
                    phase_next = PH_END;
                end else begin
                    res.ev     = EV_BADCMD;
                    phase_next = PH_HEAD0;
                end
            end
            PH_LENH: begin
                exp_len_next = {rx_byte, {BYTE_W{1'b0}}};
                phase_next   = PH_LENL;
            end
            PH_LENL: begin
                res.plen = len_full;
                if (len_full == '0 || len_full > cfg.max_len) begin
                    res.ev       = EV_BADLEN;
                    exp_len_next = '0;
                    phase_next   = PH_HEAD0;
                end else begin
                    res.ev       = EV_START;
                    exp_len_next = len_full;
                    count_next   = '0;
                    phase_next   = PH_DATA;
                end
            end
            PH_DATA: begin
                res.ev     = EV_BYTE;
                res.pbyte  = rx_byte;
                count_next = count_inc;
                if (count_inc >= exp_len_reg) begin
                    res.plast  = 1'b1;
                    phase_next = PH_END;
                end
            end
            PH_END: begin
                if (rx_byte == cfg.end_byte) begin
                    res.ev       = EV_PKTEND;
                    exp_len_next = '0;
                    phase_next   = PH_HEAD0;
                end else begin
                    res.ev     = EV_NOEND;
                    phase_next = hdr_restart;
                end
            end
            default: begin
                phase_next = hdr_restart;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD0;
            exp_len_reg <= '0;
            count_reg   <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== hw/rtl/cfd_checker.sv =====
// ----------------------------------------------------------------------------
// cfd_checker: port-level checks for the command frame deframer
// Watches result codes, field consistency and the output handshake.
// ----------------------------------------------------------------------------
module cfd_checker
    import cfd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [3:0]         m_event_res,
    input logic [BYTE_W-1:0]  m_payload_byte,
    input logic               m_payload_last,
    input logic [LEN_W-1:0]   m_payload_length
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res)
            && $stable(m_payload_byte) && $stable(m_payload_length))
        else $error("stalled result transfer changed");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_res <= EV_NOEND)
        else $error("event code out of range");

    a_last_on_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_last |-> m_event_res == EV_BYTE)
        else $error("last mark outside payload byte");

    a_len_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EV_START && m_event_res != EV_BADLEN
            |-> m_payload_length == '0)
        else $error("length shown on wrong event");

endmodule

bind command_frame_deframer cfd_checker u_cfd_checker (.*);
